// ===== sv/crc8_framed_packet_builder_defines.svh =====
// Assertion macros shared by the framed packet builder RTL.
`ifndef CRC8_FRAMED_PACKET_BUILDER_DEFINES_SVH
`define CRC8_FRAMED_PACKET_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that prop holds at every rising clock edge outside reset.
`define CRC8FPB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");
// Check that cond never holds outside reset.
`define CRC8FPB_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition: %m");
`else
`define CRC8FPB_ASSERT(lbl, clk, rst, prop)
`define CRC8FPB_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== sv/crc8fpb_pkg.sv =====
// Types, constants and the CRC-8 byte step shared by the packet builder.
`timescale 1ns / 1ps

package crc8fpb_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned ReqDataW   = 24;

   localparam logic [7:0] CrcPoly     = 8'hD5;
   localparam logic [7:0] CrcTopBit   = 8'h80;
   localparam logic [7:0] CrcInit     = 8'h00;
   localparam logic [7:0] MaxPayload  = 8'd253;
   localparam logic [7:0] SyncReset   = 8'd200;
   localparam logic [7:0] LenOverhead = 8'd2;

   // Pending-byte mask bits, in emission order.
   localparam logic [4:0] PendSync   = 5'b00001;
   localparam logic [4:0] PendLen    = 5'b00010;
   localparam logic [4:0] PendType   = 5'b00100;
   localparam logic [4:0] PendData   = 5'b01000;
   localparam logic [4:0] PendCrc    = 5'b10000;
   localparam logic [4:0] PendHeader = PendSync | PendLen | PendType;
   localparam logic [4:0] PendNone   = 5'b00000;

   // One classified item: the bytes it may emit and which of them to emit.
   typedef struct packed {
      logic [7:0] sync;
      logic [7:0] len_byte;
      logic [7:0] frame_type;
      logic [7:0] data;
      logic [7:0] crc;
      logic [4:0] pend;
   } cmd_type;

   // One byte of CRC-8, MSB first, no reflection.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CrcTopBit) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/crc8_framed_packet_builder.sv =====
// Top level of the CRC-8 framed packet builder.
`timescale 1ns / 1ps

// Builds framed packets as a byte stream: sync byte, payload length plus 2,
// frame type, payload bytes, then a CRC-8 (poly 0xD5, init 0, MSB first, no
// final XOR) over the type and payload. A start item (req_tuser high) opens a
// frame and, for a nonzero length, carries the first payload byte; every later
// item carries one payload byte. Lengths above 253 saturate to 253, a start
// inside an open frame drops that frame, and data while idle is ignored.
// Items enter at one per clock while the command queue has room; each item
// turns into up to five output bytes, and the byte sequencer sends one byte
// per clock while the receiver is ready, so the sustained rate is set by the
// output byte count: one item per clock for plain payload bytes, while a
// frame's last byte gives two bytes and a start item four or five. The
// QUEUE_DEPTH-entry command queue absorbs header bursts. The user must write
// the sync byte through csr_* only while the block is idle; it is not enforced.
module crc8_framed_packet_builder #(
   parameter int unsigned QUEUE_DEPTH = crc8fpb_pkg::QueueDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   // Sync byte register write.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [7:0]                        csr_data,    // sync_byte
   // Input items.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frame_type [7:0], payload_length [15:8], data_byte [23:16]
   input  logic [crc8fpb_pkg::ReqDataW-1:0]  req_tdata,
   input  logic                              req_tuser,   // start_req
   // Result bytes.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // out_byte
   output logic                              rsp_tlast,   // frame_last (CRC byte)
   output logic                              rsp_tuser    // run_last
);

   crc8fpb_pkg::cmd_type front_cmd, back_cmd;
   logic front_valid, front_ready;
   logic back_valid, back_ready;

   // Classify items and keep the frame's CRC and byte count.
   crc8fpb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   // Decouple the item side from the byte side.
   crc8fpb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   // Send each command's bytes, one per clock while the receiver is ready, through the output register.
   crc8fpb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/crc8fpb_front.sv =====
// Front end: takes items, tracks the open frame and its CRC, emits commands.
`timescale 1ns / 1ps
`include "crc8_framed_packet_builder_defines.svh"

module crc8fpb_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [7:0]                        csr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [crc8fpb_pkg::ReqDataW-1:0]  req_tdata,
   input  logic                              req_tuser,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output crc8fpb_pkg::cmd_type              cmd
);

   logic [7:0] sync_ff;
   logic [7:0] running_crc_ff, running_crc_in;
   logic [7:0] remaining_ff, remaining_in;
   logic       in_frame_ff, in_frame_in;

   logic       accept;
   logic [7:0] type_b, len_raw, len_sat, data_b;
   logic [7:0] crc_type, crc_base, crc_data;
   logic [7:0] rem_base, rem_next;

   assign csr_ready  = 1'b1;
   assign req_tready = cmd_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      type_b   = req_tdata[7:0];
      len_raw  = req_tdata[15:8];
      data_b   = req_tdata[23:16];
      len_sat  = (len_raw > crc8fpb_pkg::MaxPayload) ? crc8fpb_pkg::MaxPayload : len_raw;
      crc_type = crc8fpb_pkg::crc8_step(crc8fpb_pkg::CrcInit, type_b);
      crc_base = req_tuser ? crc_type : running_crc_ff;
      crc_data = crc8fpb_pkg::crc8_step(crc_base, data_b);
      rem_base = req_tuser ? len_sat : remaining_ff;
      rem_next = rem_base - 8'd1;

      cmd.sync       = sync_ff;
      cmd.len_byte   = len_sat + crc8fpb_pkg::LenOverhead;
      cmd.frame_type = type_b;
      cmd.data       = data_b;

      running_crc_in = running_crc_ff;
      remaining_in   = remaining_ff;
      in_frame_in    = in_frame_ff;

      if (req_tuser && (len_sat == 8'd0)) begin
         // Empty payload: header and CRC of the type alone, frame closes.
         cmd.pend       = crc8fpb_pkg::PendHeader | crc8fpb_pkg::PendCrc;
         cmd.crc        = crc_type;
         running_crc_in = crc_type;
         remaining_in   = 8'd0;
         in_frame_in    = 1'b0;
      end else begin
         cmd.pend = (req_tuser ? crc8fpb_pkg::PendHeader : crc8fpb_pkg::PendNone)
                  | crc8fpb_pkg::PendData
                  | ((rem_next == 8'd0) ? crc8fpb_pkg::PendCrc : crc8fpb_pkg::PendNone);
         cmd.crc        = crc_data;
         running_crc_in = crc_data;
         remaining_in   = rem_next;
         in_frame_in    = (rem_next != 8'd0);
      end
   end

   // Data while idle produces nothing.
   assign cmd_valid = req_tvalid && (req_tuser || in_frame_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff        <= crc8fpb_pkg::SyncReset;
         running_crc_ff <= crc8fpb_pkg::CrcInit;
         remaining_ff   <= 8'd0;
         in_frame_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            sync_ff <= csr_data;
         end
         if (accept && (req_tuser || in_frame_ff)) begin
            running_crc_ff <= running_crc_in;
            remaining_ff   <= remaining_in;
            in_frame_ff    <= in_frame_in;
         end
      end
   end

   `CRC8FPB_ASSERT(a_open_has_bytes, clock, reset, in_frame_ff |-> (remaining_ff != 8'd0))
   `CRC8FPB_ASSERT(a_empty_start_closes, clock, reset, (accept && req_tuser && (req_tdata[15:8] == 8'd0)) |=> !in_frame_ff)

endmodule

// ===== sv/crc8fpb_queue.sv =====
// Small command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`include "crc8_framed_packet_builder_defines.svh"

module crc8fpb_queue #(
   parameter int unsigned DEPTH = crc8fpb_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  crc8fpb_pkg::cmd_type in_cmd,
   output logic                 out_valid,
   input  logic                 out_ready,
   output crc8fpb_pkg::cmd_type out_cmd
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   crc8fpb_pkg::cmd_type entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            push, pop;

   assign in_ready  = (count_ff != CntW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   `CRC8FPB_ASSERT(a_count_bound, clock, reset, count_ff <= CntW'(DEPTH))
   `CRC8FPB_ASSERT_NEVER(a_no_empty_cmd, clock, reset, push && (in_cmd.pend == crc8fpb_pkg::PendNone))

endmodule

// ===== sv/crc8fpb_back.sv =====
// Back end: walks each command's pending bytes into a registered byte output.
`timescale 1ns / 1ps
`include "crc8_framed_packet_builder_defines.svh"

module crc8fpb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  crc8fpb_pkg::cmd_type cmd,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   crc8fpb_pkg::cmd_type cur_ff, cur_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_user_ff, rsp_user_in;

   logic       out_free, emit, pop;
   logic [4:0] lowest, rest;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      emit     = out_free && (cur_ff.pend != crc8fpb_pkg::PendNone);
      lowest   = cur_ff.pend & (~cur_ff.pend + 5'd1);
      rest     = cur_ff.pend & ~lowest;
      // Load the next command when idle or while sending the current one's last byte.
      pop      = cmd_valid && ((cur_ff.pend == crc8fpb_pkg::PendNone) ||
                               (emit && (rest == crc8fpb_pkg::PendNone)));

      cur_in = cur_ff;
      if (pop) begin
         cur_in = cmd;
      end else if (emit) begin
         cur_in.pend = rest;
      end

      if (lowest == crc8fpb_pkg::PendSync) begin
         rsp_byte_in = cur_ff.sync;
      end else if (lowest == crc8fpb_pkg::PendLen) begin
         rsp_byte_in = cur_ff.len_byte;
      end else if (lowest == crc8fpb_pkg::PendType) begin
         rsp_byte_in = cur_ff.frame_type;
      end else if (lowest == crc8fpb_pkg::PendData) begin
         rsp_byte_in = cur_ff.data;
      end else begin
         rsp_byte_in = cur_ff.crc;
      end
      rsp_last_in = (lowest == crc8fpb_pkg::PendCrc);
      rsp_user_in = (rest == crc8fpb_pkg::PendNone);

      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   assign cmd_ready  = pop;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   `CRC8FPB_ASSERT(a_crc_ends_run, clock, reset, (rsp_valid_ff && rsp_last_ff) |-> rsp_user_ff)
   `CRC8FPB_ASSERT_NEVER(a_no_pop_while_busy, clock, reset, pop && !out_free && (cur_ff.pend != crc8fpb_pkg::PendNone))

endmodule

// ===== verif/crc8_framed_packet_builder_tb.sv =====
// Self-checking testbench for the CRC-8 framed packet builder.
`timescale 1ns / 1ps

module crc8_framed_packet_builder_tb;

   localparam int IDLE_PCT      = 32;      // chance in a hundred that a side idles
   localparam int HOLD_CYCLES   = 150;     // receiver hold-off that backs up the block
   localparam int SETTLE_CYCLES = 12;      // pipe latency plus queue depth, with margin
   localparam int DRAIN_LIMIT   = 5000;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PREDICTED     = -1;      // row is checked against the predictor
   localparam int MAX_REPORTS   = 40;

   // One output byte of the framed stream.
   typedef struct packed {
      logic [7:0] data;
      logic       frame_last;
      logic       run_last;
   } rsp_byte_type;

   // One input item, with the bytes it yields typed in where they are obvious.
   typedef struct {
      logic            start;
      logic [7:0]      ftype;
      logic [7:0]      plen;
      logic [7:0]      pbyte;
      int              n_typed;
      logic            crc_end;
      logic [0:4][7:0] typed;
   } stim_row_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [7:0]                       csr_data;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [crc8fpb_pkg::ReqDataW-1:0] req_tdata;
   logic                             req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [7:0]                       rsp_tdata;
   logic                             rsp_tlast;
   logic                             rsp_tuser;

   // Predictor state, kept in step with every accepted item.
   logic [7:0] model_sync = crc8fpb_pkg::SyncReset;
   logic [7:0] model_crc  = crc8fpb_pkg::CrcInit;
   logic [7:0] model_left = 8'd0;
   logic       model_open = 1'b0;

   rsp_byte_type step_bytes[$];       // bytes caused by the item just accepted
   rsp_byte_type expected_bytes[$];   // bytes still owed by the block, oldest first
   stim_row_type cur_row;             // row now offered on the request side
   int           error_count = 0;
   int           cycle_count = 0;
   int           gen_left = 0;        // payload items the generator still plans
   bit           tx_steady = 1'b0;
   bit           rx_steady = 1'b0;
   bit           hold_off_pending = 1'b0;

   // Directed rows: extremes of every field, saturation, restarts and idle data.
   stim_row_type directed_rows [0:21] = '{
      // data while idle: ignored
      '{1'b0, 8'hA5, 8'd3,   8'h5A, 0,         1'b0, '0},
      // zero-length start right after reset: header plus CRC of type 0
      '{1'b1, 8'h00, 8'd0,   8'hFF, 4,         1'b1, {8'd200, 8'd2, 8'h00, 8'h00, 8'h00}},
      '{1'b1, 8'hFF, 8'd0,   8'h00, PREDICTED, 1'b0, '0},
      // length one: header, the byte and the CRC in one step
      '{1'b1, 8'h12, 8'd1,   8'h00, PREDICTED, 1'b0, '0},
      '{1'b1, 8'h34, 8'd1,   8'hFF, PREDICTED, 1'b0, '0},
      '{1'b1, 8'h01, 8'd3,   8'h80, 4,         1'b0, {8'd200, 8'd5, 8'h01, 8'h80, 8'h00}},
      // type and length are ignored on a payload item
      '{1'b0, 8'hFF, 8'hFF,  8'h7F, 1,         1'b0, {8'h7F, 32'h0}},
      '{1'b0, 8'h00, 8'd0,   8'h01, PREDICTED, 1'b0, '0},
      '{1'b0, 8'h3C, 8'd9,   8'hC3, 0,         1'b0, '0},
      '{1'b1, 8'h55, 8'd4,   8'hAA, 4,         1'b0, {8'd200, 8'd6, 8'h55, 8'hAA, 8'h00}},
      '{1'b0, 8'h00, 8'd0,   8'h11, 1,         1'b0, {8'h11, 32'h0}},
      // start inside an open frame: drop the old one silently
      '{1'b1, 8'h66, 8'd2,   8'h22, 4,         1'b0, {8'd200, 8'd4, 8'h66, 8'h22, 8'h00}},
      '{1'b0, 8'h00, 8'd0,   8'h33, PREDICTED, 1'b0, '0},
      // largest length, then two that saturate to it
      '{1'b1, 8'h0F, 8'd253, 8'hC3, 4,         1'b0, {8'd200, 8'd255, 8'h0F, 8'hC3, 8'h00}},
      '{1'b1, 8'hF0, 8'd254, 8'h3C, 4,         1'b0, {8'd200, 8'd255, 8'hF0, 8'h3C, 8'h00}},
      '{1'b1, 8'h80, 8'd255, 8'h00, 4,         1'b0, {8'd200, 8'd255, 8'h80, 8'h00, 8'h00}},
      // zero-length start inside a frame
      '{1'b1, 8'hC8, 8'd0,   8'hFF, PREDICTED, 1'b0, '0},
      '{1'b1, 8'hAA, 8'd2,   8'h00, PREDICTED, 1'b0, '0},
      '{1'b0, 8'h00, 8'd0,   8'hFF, PREDICTED, 1'b0, '0},
      '{1'b1, 8'h7E, 8'd128, 8'h55, 4,         1'b0, {8'd200, 8'd130, 8'h7E, 8'h55, 8'h00}},
      '{1'b1, 8'h81, 8'd127, 8'hAA, 4,         1'b0, {8'd200, 8'd129, 8'h81, 8'hAA, 8'h00}},
      '{1'b1, 8'h00, 8'd0,   8'h00, 4,         1'b1, {8'd200, 8'd2, 8'h00, 8'h00, 8'h00}}
   };

   crc8_framed_packet_builder u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------- predictor

   // CRC-8, polynomial 0xD5, fed one bit at a time, MSB first.
   function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ b[i];
         c  = {c[6:0], 1'b0} ^ (fb ? crc8fpb_pkg::CrcPoly : 8'h00);
      end
      return c;
   endfunction

   function automatic void emit_byte(input logic [7:0] b, input logic crc_end);
      rsp_byte_type r;
      r.data       = b;
      r.frame_last = crc_end;
      r.run_last   = 1'b0;
      step_bytes.push_back(r);
   endfunction

   // Pass one payload byte; close the frame with its CRC when it is the last.
   function automatic void take_payload(input logic [7:0] d);
      emit_byte(d, 1'b0);
      model_crc = crc_next(model_crc, d);
      if (model_left != 8'd0) begin
         model_left = model_left - 8'd1;
      end
      if (model_left == 8'd0) begin
         emit_byte(model_crc, 1'b1);
         model_open = 1'b0;
      end
   endfunction

   // Work out the bytes one accepted item causes, into step_bytes.
   function automatic void frame_step(input logic s, input logic [7:0] t,
                                      input logic [7:0] l, input logic [7:0] d);
      logic [7:0] len;
      step_bytes.delete();
      if (s) begin
         len = (l > crc8fpb_pkg::MaxPayload) ? crc8fpb_pkg::MaxPayload : l;
         emit_byte(model_sync, 1'b0);
         emit_byte(len + crc8fpb_pkg::LenOverhead, 1'b0);
         emit_byte(t, 1'b0);
         model_crc = crc_next(crc8fpb_pkg::CrcInit, t);
         if (len == 8'd0) begin
            emit_byte(model_crc, 1'b1);
            model_left = 8'd0;
            model_open = 1'b0;
         end else begin
            model_left = len;
            model_open = 1'b1;
            take_payload(d);
         end
      end else if (model_open) begin
         take_payload(d);
      end
      if (step_bytes.size() != 0) begin
         step_bytes[step_bytes.size() - 1].run_last = 1'b1;
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want_v);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s: got %0h, want %0h", $time, what, got, want_v);
      end
   endtask

   // Sample both channels at the rising edge: queue the bytes of each accepted
   // item first, then check the byte leaving the block against the oldest one.
   always @(posedge clock) begin
      rsp_byte_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            frame_step(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
            if (cur_row.n_typed == PREDICTED) begin
               foreach (step_bytes[k]) begin
                  expected_bytes.push_back(step_bytes[k]);
               end
            end else begin
               for (int k = 0; k < cur_row.n_typed; k++) begin
                  want.data       = cur_row.typed[k];
                  want.run_last   = (k == cur_row.n_typed - 1);
                  want.frame_last = want.run_last && cur_row.crc_end;
                  expected_bytes.push_back(want);
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("byte with nothing expected", int'(rsp_tdata), 0);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.data) begin
                  report_mismatch("out_byte", int'(rsp_tdata), int'(want.data));
               end
               if (rsp_tlast !== want.frame_last) begin
                  report_mismatch("frame_last", int'(rsp_tlast), int'(want.frame_last));
               end
               if (rsp_tuser !== want.run_last) begin
                  report_mismatch("run_last", int'(rsp_tuser), int'(want.run_last));
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving

   // Receiver: drop ready at random, or hold it low for a long stretch on
   // request so that the block's queue fills and it stalls its input.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            for (int k = 1; k < HOLD_CYCLES; k++) begin
               @(negedge clock);
            end
         end else begin
            rsp_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic stim_row_type make_row(input logic s, input logic [7:0] t,
                                             input logic [7:0] l, input logic [7:0] d);
      stim_row_type row;
      row.start   = s;
      row.ftype   = t;
      row.plen    = l;
      row.pbyte   = d;
      row.n_typed = PREDICTED;
      row.crc_end = 1'b0;
      row.typed   = '0;
      return row;
   endfunction

   // Offer one item and hold it until the block takes it. Valid stays high on
   // return so back-to-back items need no extra assignment.
   task automatic send_item(input stim_row_type row);
      @(negedge clock);
      while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      cur_row = row;
      req_tvalid <= 1'b1;
      req_tuser  <= row.start;
      req_tdata  <= {row.pbyte, row.plen, row.ftype};
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   // Wait for every owed byte, then let the pipe settle so that items which
   // cause no bytes are also through.
   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sync(input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      model_sync = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed frames of small random length; some saturated or cut
   // short by a new start, and stray data while idle as noise.
   task automatic run_random(input int count);
      int         sent;
      int         r;
      logic [7:0] len;
      sent = 0;
      while (sent < count) begin
         if (gen_left > 0 && $urandom_range(99) >= 4) begin
            send_item(make_row(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255))));
            gen_left--;
            sent++;
         end else begin
            // stray data does not count toward the item budget
            if (gen_left == 0 && $urandom_range(99) < 8) begin
               send_item(make_row(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255))));
            end
            r = $urandom_range(99);
            if (r < 10) begin
               len = 8'd0;
            end else if (r < 20) begin
               len = 8'd1;
            end else if (r < 26) begin
               len = 8'($urandom_range(254, 255));
            end else if (r < 32) begin
               len = 8'($urandom_range(13, 48));
            end else begin
               len = 8'($urandom_range(2, 12));
            end
            send_item(make_row(1'b1, 8'($urandom_range(255)), len,
                               8'($urandom_range(255))));
            sent++;
            if (len > crc8fpb_pkg::MaxPayload) begin
               gen_left = $urandom_range(1, 8);    // cut a saturated frame short
            end else if (len == 8'd0) begin
               gen_left = 0;
            end else begin
               gen_left = len - 1;
            end
         end
      end
   endtask

   // Cycle limit: give up if the run hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_data   = 8'd0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      cur_row    = make_row(1'b0, 8'd0, 8'd0, 8'd0);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows run with the sync byte at its reset value.
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i]);
      end
      drain_results();

      // Lowest sync byte, random idling on both sides.
      write_sync(8'h00);
      run_random(55);
      drain_results();

      // Highest sync byte with no idling at all.
      write_sync(8'hFF);
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      run_random(45);
      drain_results();
      tx_steady = 1'b0;
      rx_steady = 1'b0;

      // Back-pressure: keep offering payload while the receiver holds off,
      // then one frame of the largest length.
      write_sync(8'($urandom_range(1, 254)));
      tx_steady = 1'b1;
      send_item(make_row(1'b1, 8'($urandom_range(255)), 8'd40, 8'($urandom_range(255))));
      hold_off_pending = 1'b1;
      repeat (39) begin
         send_item(make_row(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255))));
      end
      tx_steady = 1'b0;
      send_item(make_row(1'b1, 8'($urandom_range(255)), crc8fpb_pkg::MaxPayload,
                         8'($urandom_range(255))));
      repeat (252) begin
         send_item(make_row(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255))));
      end
      gen_left = 0;
      drain_results();

      // Random sync byte, random idling again.
      write_sync(8'($urandom_range(255)));
      run_random(55);
      drain_results();

      if (expected_bytes.size() != 0) begin
         report_mismatch("bytes never delivered", 0, expected_bytes.size());
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/crc8fpb_pkg.sv
sv/crc8fpb_front.sv
sv/crc8fpb_queue.sv
sv/crc8fpb_back.sv
sv/crc8_framed_packet_builder.sv
verif/crc8_framed_packet_builder_tb.sv
